[hdl/rht_pkg.sv]
// Package for the reference-counted handle table: types, codes and defaults.
package rht_pkg;

  localparam int ENTRIES_DEF = 512;

  localparam int ID_W     = 15;
  localparam int HDL_W    = 32;
  localparam int CNT_W    = 16;
  localparam int SLOT_W   = 9;
  localparam int USED_W   = 10;
  localparam int STAT_W   = 3;
  localparam int ACTION_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_UPDATE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_REMOVED     = 3'd0,
    STAT_DECREMENTED = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_NULL        = 3'd3,
    STAT_HIT         = 3'd4,
    STAT_INSERTED    = 3'd5,
    STAT_FULL        = 3'd6,
    STAT_UPDATED     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_MOVE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic             by_handle;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
  } unit_req_t;

  typedef struct packed {
    logic             match;
    logic             cnt_one;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;
  } unit_rsp_t;

endpackage

[hdl/rht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rht_unit.sv]
// Shared key compare and reference count arithmetic unit.
module rht_unit
  import rht_pkg::*;
(
  input  unit_req_t req,
  input  entry_t    ent,
  output unit_rsp_t rsp
);

  always_comb begin
    rsp.match   = req.by_handle ? (ent.hdl == req.hdl) : (ent.id == req.id);
    rsp.cnt_one = (ent.cnt == CNT_W'(1));
    rsp.cnt_inc = (ent.cnt == '1) ? ent.cnt : ent.cnt + CNT_W'(1);
    rsp.cnt_dec = ent.cnt - CNT_W'(1);
  end

endmodule

[hdl/refcounted_handle_table.sv]
// Reference-counted handle table: top level with scan sequencer.
//
//  channel   handshake        payload
//  request   start / busy     action, obj_id, handle, new_handle
//  result    done (1 cycle)   status, slot, handle_out, ref_count, entries_used
//
// Each scan reads one packed entry per cycle. A miss scans every used entry; a match
// stops the scan at its slot, and a removal adds the move of the last entry.
// The result shows in the same cycle that busy falls.
// A null operand or unused action gives its result the cycle after the request
// and busy does not rise. Reset empties the table at once, no clearing pass.
// Results are shown for one cycle and cannot be held off.
module refcounted_handle_table
  import rht_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [ID_W-1:0]     obj_id,
  input  logic [HDL_W-1:0]    handle,
  input  logic [HDL_W-1:0]    new_handle,
  output logic                done,
  output logic [STAT_W-1:0]   status,
  output logic [SLOT_W-1:0]   slot,
  output logic [HDL_W-1:0]    handle_out,
  output logic [CNT_W-1:0]    ref_count,
  output logic [USED_W-1:0]   entries_used
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t            state, state_next;
  logic [CW-1:0]     issue_idx, issue_idx_next;
  logic              inflight, inflight_next;
  logic [IW-1:0]     cmp_idx, cmp_idx_next;
  logic [IW-1:0]     slot_idx, slot_idx_next;
  entry_t            ent, ent_next;
  logic              found, found_next;
  logic [CW-1:0]     used_cnt, used_cnt_next;
  action_t           act, act_next;
  logic [ID_W-1:0]   key_id, key_id_next;
  logic [HDL_W-1:0]  key_hdl, key_hdl_next;
  logic [HDL_W-1:0]  nhdl, nhdl_next;
  logic              done_next;
  logic [STAT_W-1:0] status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [HDL_W-1:0]  handle_out_next;
  logic [CNT_W-1:0]  ref_count_next;
  logic [USED_W-1:0] entries_used_next;

  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  logic [IW-1:0]     raddr;
  entry_t            rdata;
  logic [CW-1:0]     last_idx;
  unit_req_t         ureq;
  unit_rsp_t         ursp;
  entry_t            uent;

  rht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ureq.by_handle = (act != ACT_GET);
  assign ureq.id        = key_id;
  assign ureq.hdl       = key_hdl;
  assign uent           = (state == ST_SCAN) ? rdata : ent;

  rht_unit u_unit (
    .req(ureq),
    .ent(uent),
    .rsp(ursp)
  );

  assign busy     = (state != ST_IDLE);
  assign last_idx = used_cnt - CW'(1);
  assign raddr    = (state == ST_APPLY) ? last_idx[IW-1:0] : issue_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      inflight <= 1'b0;
      used_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      inflight <= inflight_next;
      used_cnt <= used_cnt_next;
      done     <= done_next;
    end
    issue_idx    <= issue_idx_next;
    cmp_idx      <= cmp_idx_next;
    slot_idx     <= slot_idx_next;
    ent          <= ent_next;
    found        <= found_next;
    act          <= act_next;
    key_id       <= key_id_next;
    key_hdl      <= key_hdl_next;
    nhdl         <= nhdl_next;
    status       <= status_next;
    slot         <= slot_next;
    handle_out   <= handle_out_next;
    ref_count    <= ref_count_next;
    entries_used <= entries_used_next;
  end

  always_comb begin
    state_next        = state;
    issue_idx_next    = issue_idx;
    inflight_next     = inflight;
    cmp_idx_next      = cmp_idx;
    slot_idx_next     = slot_idx;
    ent_next          = ent;
    found_next        = found;
    used_cnt_next     = used_cnt;
    act_next          = act;
    key_id_next       = key_id;
    key_hdl_next      = key_hdl;
    nhdl_next         = nhdl;
    done_next         = 1'b0;
    status_next       = status;
    slot_next         = slot;
    handle_out_next   = handle_out;
    ref_count_next    = ref_count;
    entries_used_next = entries_used;
    we                = 1'b0;
    waddr             = slot_idx;
    wdata             = ent;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          act_next          = action_t'(action);
          key_id_next       = obj_id;
          key_hdl_next      = handle;
          nhdl_next         = new_handle;
          issue_idx_next    = '0;
          inflight_next     = 1'b0;
          slot_next         = '0;
          handle_out_next   = '0;
          ref_count_next    = '0;
          entries_used_next = USED_W'(used_cnt);
          unique case (action_t'(action))
            ACT_GET: state_next = ST_SCAN;
            ACT_RELEASE: begin
              if (handle == '0) begin
                done_next   = 1'b1;
                status_next = STAT_NULL;
              end else begin
                state_next = ST_SCAN;
              end
            end
            ACT_UPDATE: begin
              if (handle == '0 || new_handle == '0) begin
                done_next   = 1'b1;
                status_next = STAT_NULL;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = STAT_NOT_FOUND;
            end
          endcase
        end
      end

      ST_SCAN: begin
        inflight_next = 1'b0;
        if (inflight && ursp.match) begin
          found_next    = 1'b1;
          slot_idx_next = cmp_idx;
          ent_next      = rdata;
          state_next    = ST_APPLY;
        end else if (issue_idx < used_cnt) begin
          inflight_next  = 1'b1;
          cmp_idx_next   = issue_idx[IW-1:0];
          issue_idx_next = issue_idx + CW'(1);
        end else if (!inflight) begin
          found_next = 1'b0;
          state_next = ST_APPLY;
        end
      end

      ST_APPLY: begin
        state_next        = ST_IDLE;
        done_next         = 1'b1;
        slot_next         = '0;
        handle_out_next   = '0;
        ref_count_next    = '0;
        entries_used_next = USED_W'(used_cnt);
        status_next       = STAT_NOT_FOUND;
        unique case (act)
          ACT_GET: begin
            if (found) begin
              we              = 1'b1;
              wdata           = '{id: ent.id, hdl: ent.hdl, cnt: ursp.cnt_inc};
              status_next     = STAT_HIT;
              slot_next       = SLOT_W'(slot_idx);
              handle_out_next = ent.hdl;
              ref_count_next  = ursp.cnt_inc;
            end else if (used_cnt == CW'(ENTRIES)) begin
              status_next = STAT_FULL;
              slot_next   = SLOT_W'(used_cnt);
            end else begin
              we                = 1'b1;
              waddr             = used_cnt[IW-1:0];
              wdata             = '{id: key_id, hdl: key_hdl, cnt: CNT_W'(1)};
              used_cnt_next     = used_cnt + CW'(1);
              status_next       = STAT_INSERTED;
              slot_next         = SLOT_W'(used_cnt);
              handle_out_next   = key_hdl;
              ref_count_next    = CNT_W'(1);
              entries_used_next = USED_W'(used_cnt + CW'(1));
            end
          end
          ACT_RELEASE: begin
            if (found && ursp.cnt_one) begin
              done_next  = 1'b0;
              state_next = ST_MOVE;
            end else if (found) begin
              we              = 1'b1;
              wdata           = '{id: ent.id, hdl: ent.hdl, cnt: ursp.cnt_dec};
              status_next     = STAT_DECREMENTED;
              slot_next       = SLOT_W'(slot_idx);
              handle_out_next = ent.hdl;
              ref_count_next  = ursp.cnt_dec;
            end
          end
          ACT_UPDATE: begin
            if (found) begin
              we              = 1'b1;
              wdata           = '{id: ent.id, hdl: nhdl, cnt: ent.cnt};
              status_next     = STAT_UPDATED;
              slot_next       = SLOT_W'(slot_idx);
              handle_out_next = nhdl;
              ref_count_next  = ent.cnt;
            end
          end
          default: status_next = STAT_NOT_FOUND;
        endcase
      end

      ST_MOVE: begin
        // last entry fills the freed slot
        we                = 1'b1;
        wdata             = rdata;
        used_cnt_next     = last_idx;
        state_next        = ST_IDLE;
        done_next         = 1'b1;
        status_next       = STAT_REMOVED;
        slot_next         = SLOT_W'(slot_idx);
        handle_out_next   = '0;
        ref_count_next    = '0;
        entries_used_next = USED_W'(last_idx);
      end

      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> issue_idx <= used_cnt)
    else $error("scan index past last entry");

  a_move_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOVE |=> used_cnt == $past(used_cnt) - CW'(1))
    else $error("removal did not shrink the table");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_INSERTED |-> ref_count == CNT_W'(1) && entries_used != '0)
    else $error("insert reported wrong count");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the reference-counted handle table.
module tb_top
  import rht_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS = ENTRIES_DEF;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [HDL_W-1:0]   hdl;
    logic [CNT_W-1:0]   cnt;
    logic [USED_W-1:0]  used;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     obj_id;
  logic [HDL_W-1:0]    handle;
  logic [HDL_W-1:0]    new_handle;
  logic                done;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot;
  logic [HDL_W-1:0]    handle_out;
  logic [CNT_W-1:0]    ref_count;
  logic [USED_W-1:0]   entries_used;

  // shadow copy of the table contents
  logic [ID_W-1:0]  shadow_id  [N_SLOTS];
  logic [HDL_W-1:0] shadow_hdl [N_SLOTS];
  logic [CNT_W-1:0] shadow_cnt [N_SLOTS];
  int               shadow_used = 0;

  table_result_t pending_results[$];
  int            mismatch_count = 0;
  int            sender_idle = 0;

  refcounted_handle_table #(.ENTRIES(N_SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .obj_id(obj_id), .handle(handle), .new_handle(new_handle),
    .done(done), .status(status), .slot(slot), .handle_out(handle_out),
    .ref_count(ref_count), .entries_used(entries_used)
  );

  always #6 clk = ~clk;

  initial begin
    #200ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // lowest packed slot matching the key, or shadow_used when absent
  function automatic int lookup(bit by_handle, logic [HDL_W-1:0] key);
    int i;
    for (i = 0; i < shadow_used; i++) begin
      if (by_handle ? (shadow_hdl[i] == key) : (shadow_id[i] == key[ID_W-1:0])) return i;
    end
    return shadow_used;
  endfunction

  function automatic table_result_t table_predict(action_t act, logic [ID_W-1:0] id,
                                                  logic [HDL_W-1:0] h, logic [HDL_W-1:0] nh);
    table_result_t r;
    int i;
    r.status = STAT_NOT_FOUND;
    r.slot = '0;
    r.hdl = '0;
    r.cnt = '0;
    case (act)
      ACT_GET: begin
        i = lookup(1'b0, HDL_W'(id));
        if (i < shadow_used) begin
          if (shadow_cnt[i] != '1) shadow_cnt[i] = shadow_cnt[i] + 1'b1;
          r.status = STAT_HIT;
          r.slot = SLOT_W'(i);
          r.hdl = shadow_hdl[i];
          r.cnt = shadow_cnt[i];
        end else if (shadow_used >= N_SLOTS) begin
          r.status = STAT_FULL;
          r.slot = SLOT_W'(shadow_used);
        end else begin
          shadow_id[shadow_used] = id;
          shadow_hdl[shadow_used] = h;
          shadow_cnt[shadow_used] = CNT_W'(1);
          r.status = STAT_INSERTED;
          r.slot = SLOT_W'(shadow_used);
          r.hdl = h;
          r.cnt = CNT_W'(1);
          shadow_used++;
        end
      end
      ACT_RELEASE: begin
        if (h == '0) begin
          r.status = STAT_NULL;
        end else begin
          i = lookup(1'b1, h);
          if (i < shadow_used) begin
            r.slot = SLOT_W'(i);
            if (shadow_cnt[i] == CNT_W'(1)) begin
              // last entry moves into the freed slot
              shadow_id[i] = shadow_id[shadow_used-1];
              shadow_hdl[i] = shadow_hdl[shadow_used-1];
              shadow_cnt[i] = shadow_cnt[shadow_used-1];
              shadow_used--;
              r.status = STAT_REMOVED;
            end else begin
              shadow_cnt[i] = shadow_cnt[i] - 1'b1;
              r.status = STAT_DECREMENTED;
              r.hdl = shadow_hdl[i];
              r.cnt = shadow_cnt[i];
            end
          end
        end
      end
      ACT_UPDATE: begin
        if (h == '0 || nh == '0) begin
          r.status = STAT_NULL;
        end else begin
          i = lookup(1'b1, h);
          if (i < shadow_used) begin
            shadow_hdl[i] = nh;
            r.status = STAT_UPDATED;
            r.slot = SLOT_W'(i);
            r.hdl = nh;
            r.cnt = shadow_cnt[i];
          end
        end
      end
      default: ;
    endcase
    r.used = USED_W'(shadow_used);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [HDL_W-1:0] got, logic [HDL_W-1:0] want);
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic send_req(action_t act, logic [ID_W-1:0] id, logic [HDL_W-1:0] h,
                          logic [HDL_W-1:0] nh);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    obj_id <= id;
    handle <= h;
    new_handle <= nh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(table_predict(act, id, h, nh));
  endtask

  // hold requests off until every result is back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", HDL_W'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", HDL_W'(status), HDL_W'(want.status));
        if (slot !== want.slot) report_mismatch("slot", HDL_W'(slot), HDL_W'(want.slot));
        if (handle_out !== want.hdl) report_mismatch("handle_out", handle_out, want.hdl);
        if (ref_count !== want.cnt) report_mismatch("ref_count", HDL_W'(ref_count), HDL_W'(want.cnt));
        if (entries_used !== want.used) begin
          report_mismatch("entries_used", HDL_W'(entries_used), HDL_W'(want.used));
        end
      end
    end
  end

  task automatic test_directed;
    sender_idle = 37;
    send_req(ACT_GET, '0, '1, '0);
    send_req(ACT_GET, '1, 32'd1, '1);
    send_req(ACT_GET, '0, 32'd7, '0);
    send_req(ACT_GET, 15'd100, '0, '0);
    send_req(ACT_RELEASE, '1, '0, '1);
    send_req(ACT_RELEASE, '0, 32'h1234_5678, '0);
    send_req(ACT_RELEASE, '0, '1, '0);
    send_req(ACT_UPDATE, '0, '0, 32'd5);
    send_req(ACT_UPDATE, '0, 32'd1, '0);
    send_req(ACT_UPDATE, '0, 32'd1, 32'd1);
    send_req(ACT_UPDATE, '0, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
    send_req(ACT_UPDATE, '1, 32'd1, 32'h8000_0000);
    send_req(ACT_NONE, ID_W'($urandom), $urandom, $urandom);
    send_req(ACT_NONE, '1, '1, '1);
    send_req(ACT_RELEASE, '0, '1, '0);
    send_req(ACT_GET, 15'd200, 32'd2, '0);
    send_req(ACT_GET, 15'd201, 32'd2, '0);
    send_req(ACT_RELEASE, '0, 32'd2, '0);
    send_req(ACT_RELEASE, '0, 32'd2, '0);
    send_req(ACT_RELEASE, '0, 32'h8000_0000, '0);
    send_req(ACT_GET, '1, 32'h0000_FFFF, '0);
    drain;
  endtask

  task automatic test_random(int n_req, int idle_pct);
    int pick;
    int k;
    logic [ID_W-1:0] id;
    logic [HDL_W-1:0] h;
    logic [HDL_W-1:0] nh;
    sender_idle = idle_pct;
    repeat (n_req) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      id = ID_W'($urandom);
      h = $urandom;
      nh = $urandom;
      if (pick < 45) begin
        // small id pool keeps hits frequent and the table short
        if (k < 7) id = ID_W'($urandom_range(0, 47));
        if (k == 9) h = '0;
        send_req(ACT_GET, id, h, nh);
      end else begin
        if (k < 7 && shadow_used > 0) h = shadow_hdl[$urandom_range(0, shadow_used-1)];
        else if (k == 7) h = '0;
        if (pick < 78) begin
          send_req(ACT_RELEASE, id, h, nh);
        end else if (pick < 95) begin
          k = $urandom_range(0, 9);
          if (k == 0) nh = '0;
          else if (k == 1) nh = h;
          else if (k == 2 && shadow_used > 0) nh = shadow_hdl[$urandom_range(0, shadow_used-1)];
          send_req(ACT_UPDATE, id, h, nh);
        end else begin
          send_req(ACT_NONE, id, h, nh);
        end
      end
    end
    drain;
  endtask

  task automatic test_table_full;
    int base;
    int next_id;
    base = shadow_used;
    next_id = 20000;
    sender_idle = 0;
    while (shadow_used < N_SLOTS) begin
      send_req(ACT_GET, ID_W'(next_id), 32'hF000_0000 | next_id, $urandom);
      next_id++;
    end
    while (lookup(1'b0, HDL_W'(next_id)) < shadow_used) next_id++;
    send_req(ACT_GET, ID_W'(next_id), 32'hF000_0000 | next_id, $urandom);
    send_req(ACT_GET, shadow_id[N_SLOTS-1], $urandom, $urandom);
    send_req(ACT_UPDATE, ID_W'($urandom), shadow_hdl[N_SLOTS-1], 32'h0BAD_F00D);
    send_req(ACT_RELEASE, ID_W'($urandom), shadow_hdl[N_SLOTS-2], $urandom);
    send_req(ACT_GET, ID_W'(next_id), 32'hF000_0000 | next_id, $urandom);
    send_req(ACT_GET, ID_W'(next_id + 1), 32'hF000_0001 | next_id, $urandom);
    drain;
    // shrink back to the earlier size from the tail
    while (shadow_used > base) begin
      send_req(ACT_RELEASE, ID_W'($urandom), shadow_hdl[shadow_used-1], $urandom);
    end
    drain;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_GET;
    obj_id = '0;
    handle = '0;
    new_handle = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed;
    test_random(60, 37);
    test_random(60, 53);
    test_table_full;
    test_random(60, 0);
    drain;
    repeat (N_SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
